// ===== hdl/mpc_pkg.sv =====
// Shared types and constants of the Mandelbrot pixel classifier.
// Holds the item structs, the class and register codes and the default widths.
// No dependencies.
package mpc_pkg;

    // Default coordinate format: signed, 48 bits, 43 of them fraction bits.
    localparam int DEF_COORD_WIDTH = 48;
    localparam int DEF_FRAC_BITS = 43;

    // Width of the pixel offsets carried in an input item.
    localparam int PIXEL_INDEX_WIDTH = 12;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Iteration limit after reset.
    localparam logic [7:0] MAX_ITER_RESET = 8'd50;

    // Number of quiet steps after which an orbit counts as settled.
    localparam logic [2:0] CALM_LIMIT = 3'd5;

    // Pixel classes.
    localparam logic [1:0] CLS_ESCAPED = 2'd0;
    localparam logic [1:0] CLS_INSIDE = 2'd1;
    localparam logic [1:0] CLS_DISC = 2'd2;
    localparam logic [1:0] CLS_OUTSIDE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_OFFSET_RE = 3'd0;
    localparam logic [2:0] REG_OFFSET_IM = 3'd1;
    localparam logic [2:0] REG_STEP_RE = 3'd2;
    localparam logic [2:0] REG_STEP_IM = 3'd3;
    localparam logic [2:0] REG_MAX_ITER = 3'd4;

    typedef struct packed {
        logic signed [PIXEL_INDEX_WIDTH-1:0] column_offset;
        logic signed [PIXEL_INDEX_WIDTH-1:0] row_offset;
    } t_pixel_in;

    typedef struct packed {
        logic [1:0] pixel_class;
        logic [7:0] iteration_count;
    } t_pixel_out;

    // Verdict of the front for one pixel: either final, or the orbit must be run.
    typedef struct packed {
        logic       iterate;
        logic [1:0] pixel_class;
    } t_job_tag;

endpackage

// ===== hdl/mandelbrot_pixel_classifier.sv =====
// Top level of the Mandelbrot pixel classifier: configuration registers, front, queue, back.
// Uses mpc_pkg, mpc_front, mpc_queue and mpc_back.
//
// Each input item is one pixel, given as signed column and row offsets from the view
// origin. The front forms the point c from the offsets and the configured step sizes,
// then tests it against radius 2 and four fixed discs on a shared two-stage squarer.
// A point outside radius 2 leaves as class 3 with count 1, a point inside a disc as
// class 2. Every point is handed through a two-entry queue to the back, which passes
// these verdicts on and for every other point iterates z = z*z + c from zero. Each
// orbit step runs through three states (partial products, their sum, then the escape
// test and update); the default iteration limit is 50. The result is reported as
// escaped (class 0) with its step count, or as inside (class 1). The front works on the
// next item while the back iterates, and a finished result waits in the output register
// without holding either side. Configuration registers should be written only while no
// item is in flight.
module mandelbrot_pixel_classifier
    import mpc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_pixel_in              i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_pixel_out             o_out_data,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int QW = $bits(t_job_tag) + 2 * W;

    // Reset step is four over six hundred, rounded to nearest.
    localparam longint unsigned ONE = 64'd1 << F;
    localparam longint unsigned C_STEP = (ONE / 600) * 4 + ((ONE % 600) * 4 + 300) / 600;
    localparam logic [W-2:0] STEP_RESET = (W - 1)'(C_STEP);

    // Configuration registers.
    logic signed [W-1:0] r_offset_re;
    logic signed [W-1:0] r_offset_im;
    logic [W-2:0]        r_step_re;
    logic [W-2:0]        r_step_im;
    logic [7:0]          r_max_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_re <= '0;
            r_offset_im <= '0;
            r_step_re   <= STEP_RESET;
            r_step_im   <= STEP_RESET;
            r_max_iter  <= MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            // Writes to indexes beyond the register list are dropped.
            case (i_cfg_index)
                REG_OFFSET_RE: r_offset_re <= i_cfg_data;
                REG_OFFSET_IM: r_offset_im <= i_cfg_data;
                REG_STEP_RE:   r_step_re   <= i_cfg_data[W-2:0];
                REG_STEP_IM:   r_step_im   <= i_cfg_data[W-2:0];
                REG_MAX_ITER:  r_max_iter  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front to queue.
    logic                push;
    logic                q_full;
    t_job_tag            f_tag;
    logic signed [W-1:0] f_cr;
    logic signed [W-1:0] f_ci;

    // Queue to back.
    logic                pop;
    logic                q_empty;
    logic [QW-1:0]       q_out;
    t_job_tag            b_tag;
    logic signed [W-1:0] b_cr;
    logic signed [W-1:0] b_ci;

    assign {b_tag, b_cr, b_ci} = q_out;

    mpc_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_offset_re(r_offset_re),
        .i_offset_im(r_offset_im),
        .i_step_re  (r_step_re),
        .i_step_im  (r_step_im),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job_tag  (f_tag),
        .o_job_cr   (f_cr),
        .o_job_ci   (f_ci)
    );

    mpc_queue #(
        .DATA_WIDTH(QW),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_tag, f_cr, f_ci}),
        .o_full (q_full),
        .i_pop  (pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    mpc_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .i_job_tag       (b_tag),
        .i_job_cr        (b_cr),
        .i_job_ci        (b_ci),
        .i_max_iterations(r_max_iter),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

endmodule

// ===== hdl/mpc_queue.sv =====
// Small first-in first-out queue that carries jobs from the front to the back.
// Depends on nothing but its parameters.
module mpc_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]         r_wr;
    logic [PW-1:0]         r_rd;
    logic [CW-1:0]         r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue holds more jobs than it has entries");

endmodule

// ===== hdl/mpc_front.sv =====
// Front of the classifier: forms the point c of a pixel and runs the radius and disc tests.
// Uses mpc_pkg; feeds mpc_queue.
module mpc_front
    import mpc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  t_pixel_in                     i_in_data,
    input  logic signed [COORD_WIDTH-1:0] i_offset_re,
    input  logic signed [COORD_WIDTH-1:0] i_offset_im,
    input  logic [COORD_WIDTH-2:0]        i_step_re,
    input  logic [COORD_WIDTH-2:0]        i_step_im,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_job_tag                      o_job_tag,
    output logic signed [COORD_WIDTH-1:0] o_job_cr,
    output logic signed [COORD_WIDTH-1:0] o_job_ci
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int PW = PIXEL_INDEX_WIDTH + W;
    localparam int LO = W / 2;
    localparam int HI = W - LO;
    localparam int SW = 2 * W;
    localparam int NSQ = 6;
    localparam int TW = $clog2(NSQ);

    localparam longint unsigned ONE = 64'd1 << F;
    localparam longint unsigned C_024 = (ONE / 100) * 24 + ((ONE % 100) * 24 + 50) / 100;
    localparam longint unsigned C_030 = (ONE / 100) * 30 + ((ONE % 100) * 30 + 50) / 100;
    localparam longint unsigned C_049 = (ONE / 100) * 49 + ((ONE % 100) * 49 + 50) / 100;
    localparam longint unsigned C_023 = (ONE / 100) * 23 + ((ONE % 100) * 23 + 50) / 100;

    localparam logic signed [W-1:0] ONE_W = W'(ONE);
    localparam logic signed [W-1:0] A24 = W'(C_024);
    localparam logic signed [W-1:0] B30 = W'(C_030);
    localparam logic [SW:0] R49 = (SW + 1)'(C_049);
    localparam logic [SW:0] R30 = (SW + 1)'(C_030);
    localparam logic [SW:0] R23 = (SW + 1)'(C_023);
    localparam logic [SW:0] R49SQ = R49 * R49;
    localparam logic [SW:0] R30SQ = R30 * R30;
    localparam logic [SW:0] R23SQ = R23 * R23;
    localparam logic [SW:0] FOUR = (SW + 1)'(1) << (2 * F + 2);

    localparam logic signed [PW-1:0] P_HI = {{(PW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [PW-1:0] P_LO = {{(PW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0] W_HI = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] W_LO = {1'b1, {(W - 1){1'b0}}};

    typedef enum logic [1:0] {
        F_IDLE,
        F_COORD,
        F_SQ,
        F_TEST
    } t_front_state;

    t_front_state r_state;

    logic signed [PW-1:0] r_prod_re;
    logic signed [PW-1:0] r_prod_im;
    logic signed [W-1:0]  r_cr;
    logic signed [W-1:0]  r_ci;
    logic [2:0]           r_sq_cnt;

    // Two-stage squarer: partial products, then their sum.
    logic                      r_v1;
    logic [TW-1:0]             r_tag;
    logic signed [W+HI-1:0]    r_p1;
    logic signed [W+LO:0]      r_p0;
    logic [SW-1:0]             r_sq [NSQ];

    logic signed [W-1:0]    sq_op;
    logic signed [HI-1:0]   sq_xh;
    logic signed [LO:0]     sq_xl;
    logic signed [W+HI-1:0] sq_p1;
    logic signed [W+LO:0]   sq_p0;
    logic signed [SW-1:0]   sq_sum;

    logic signed [PW-1:0] col_prod;
    logic signed [PW-1:0] row_prod;

    logic [SW:0] norm_c;
    logic        outside;
    logic        disc_hit;

    function automatic logic signed [W-1:0] sat_mul(input logic signed [PW-1:0] p);
        logic signed [W-1:0] r;
        if (p > P_HI) begin
            r = W_HI;
        end else if (p < P_LO) begin
            r = W_LO;
        end else begin
            r = p[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic signed [W-1:0] r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            r = s[W] ? W_LO : W_HI;
        end else begin
            r = s[W-1:0];
        end
        return r;
    endfunction

    assign o_in_ready = (r_state == F_IDLE);

    assign col_prod = i_in_data.column_offset * $signed({1'b0, i_step_re});
    assign row_prod = i_in_data.row_offset * $signed({1'b0, i_step_im});

    always_comb begin
        unique case (r_sq_cnt)
            3'd0:    sq_op = r_cr;
            3'd1:    sq_op = r_ci;
            3'd2:    sq_op = r_cr + A24;
            3'd3:    sq_op = r_ci + B30;
            3'd4:    sq_op = r_ci - B30;
            3'd5:    sq_op = r_cr + ONE_W;
            default: sq_op = r_cr;
        endcase
    end

    assign sq_xh  = sq_op[W-1:LO];
    assign sq_xl  = $signed({1'b0, sq_op[LO-1:0]});
    assign sq_p1  = sq_op * sq_xh;
    assign sq_p0  = sq_op * sq_xl;
    assign sq_sum = ({{(SW - W - HI){r_p1[W+HI-1]}}, r_p1} <<< LO)
                  + {{(SW - W - LO - 1){r_p0[W+LO]}}, r_p0};

    // The point lies outside radius 2, or in one of the four shortcut discs.
    assign norm_c   = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
    assign outside  = (norm_c > FOUR);
    assign disc_hit = (({1'b0, r_sq[2]} + {1'b0, r_sq[1]}) <= R49SQ)
                   || (({1'b0, r_sq[0]} + {1'b0, r_sq[3]}) <= R30SQ)
                   || (({1'b0, r_sq[0]} + {1'b0, r_sq[4]}) <= R30SQ)
                   || (({1'b0, r_sq[5]} + {1'b0, r_sq[1]}) <= R23SQ);

    assign o_push = (r_state == F_TEST) && !i_q_full;
    assign o_job_tag.iterate = !outside && !disc_hit;
    assign o_job_tag.pixel_class = outside ? CLS_OUTSIDE : (disc_hit ? CLS_DISC : CLS_ESCAPED);
    assign o_job_cr = r_cr;
    assign o_job_ci = r_ci;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_sq_cnt <= '0;
            r_v1     <= 1'b0;
        end else begin
            r_v1 <= (r_state == F_SQ) && (r_sq_cnt < 3'(NSQ));
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= F_COORD;
                    end
                end
                F_COORD: begin
                    r_sq_cnt <= '0;
                    r_state  <= F_SQ;
                end
                F_SQ: begin
                    r_sq_cnt <= r_sq_cnt + 1'b1;
                    if (r_sq_cnt == 3'(NSQ)) begin
                        r_state <= F_TEST;
                    end
                end
                F_TEST: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_prod_re <= col_prod;
            r_prod_im <= row_prod;
        end
        if (r_state == F_COORD) begin
            r_cr <= sat_add(i_offset_re, sat_mul(r_prod_re));
            r_ci <= sat_add(i_offset_im, sat_mul(r_prod_im));
        end
        r_tag <= r_sq_cnt[TW-1:0];
        r_p1  <= sq_p1;
        r_p0  <= sq_p0;
        if (r_v1) begin
            r_sq[r_tag] <= sq_sum;
        end
    end

endmodule

// ===== hdl/mpc_back.sv =====
// Back of the classifier: runs the escape-time orbit and holds the output register.
// Uses mpc_pkg; fed by mpc_queue.
module mpc_back
    import mpc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  t_job_tag                      i_job_tag,
    input  logic signed [COORD_WIDTH-1:0] i_job_cr,
    input  logic signed [COORD_WIDTH-1:0] i_job_ci,
    input  logic [7:0]                    i_max_iterations,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output t_pixel_out                    o_out_data
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int LO = W / 2;
    localparam int HI = W - LO;
    localparam int SW = 2 * W;

    localparam longint unsigned ONE = 64'd1 << F;
    localparam longint unsigned EPS_DEN = 64'd10000000000;
    localparam longint unsigned C_EPS = (ONE / EPS_DEN) + ((ONE % EPS_DEN) + EPS_DEN / 2) / EPS_DEN;
    localparam logic signed [W:0] EPS_P = (W + 1)'(C_EPS);
    localparam logic signed [W:0] EPS_N = -EPS_P;
    localparam logic [SW:0] FOUR = (SW + 1)'(1) << (2 * F + 2);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_EVAL,
        B_DONE
    } t_back_state;

    t_back_state r_state;
    logic        r_out_valid;
    t_pixel_out  r_out_data;
    t_pixel_out  r_res;
    logic [7:0]  r_n;
    logic [2:0]  r_calm;

    logic signed [W-1:0] r_cr;
    logic signed [W-1:0] r_ci;
    logic signed [W-1:0] r_zr;
    logic signed [W-1:0] r_zi;

    logic signed [W+HI-1:0] r_xx1;
    logic signed [W+LO:0]   r_xx0;
    logic signed [W+HI-1:0] r_yy1;
    logic signed [W+LO:0]   r_yy0;
    logic signed [W+HI-1:0] r_xy1;
    logic signed [W+LO:0]   r_xy0;
    logic signed [SW-1:0]   r_xx;
    logic signed [SW-1:0]   r_yy;
    logic signed [SW-1:0]   r_xy;

    logic signed [HI-1:0]   zr_h;
    logic signed [LO:0]     zr_l;
    logic signed [HI-1:0]   zi_h;
    logic signed [LO:0]     zi_l;
    logic signed [W+HI-1:0] m_xx1;
    logic signed [W+LO:0]   m_xx0;
    logic signed [W+HI-1:0] m_yy1;
    logic signed [W+LO:0]   m_yy0;
    logic signed [W+HI-1:0] m_xy1;
    logic signed [W+LO:0]   m_xy0;

    logic [SW:0]          norm_z;
    logic                 escaped;
    logic signed [SW-1:0] xx_sh;
    logic signed [SW-1:0] yy_sh;
    logic signed [SW-1:0] xy_sh;
    logic signed [W-1:0]  nr;
    logic signed [W-1:0]  ni;
    logic signed [W:0]    dr;
    logic signed [W:0]    di;
    logic                 quiet;

    function automatic logic signed [SW-1:0] combine_pp(input logic signed [W+HI-1:0] p1,
                                                        input logic signed [W+LO:0] p0);
        return ({{(SW - W - HI){p1[W+HI-1]}}, p1} <<< LO) + {{(SW - W - LO - 1){p0[W+LO]}}, p0};
    endfunction

    // Each square is split on its second operand into a signed upper and an unsigned lower half.
    assign zr_h  = r_zr[W-1:LO];
    assign zr_l  = $signed({1'b0, r_zr[LO-1:0]});
    assign zi_h  = r_zi[W-1:LO];
    assign zi_l  = $signed({1'b0, r_zi[LO-1:0]});
    assign m_xx1 = r_zr * zr_h;
    assign m_xx0 = r_zr * zr_l;
    assign m_yy1 = r_zi * zi_h;
    assign m_yy0 = r_zi * zi_l;
    assign m_xy1 = r_zr * zi_h;
    assign m_xy0 = r_zr * zi_l;

    // The exact squares decide escape; the floored ones give the next z.
    assign norm_z  = {1'b0, r_xx} + {1'b0, r_yy};
    assign escaped = (norm_z > FOUR);
    assign xx_sh   = r_xx >>> F;
    assign yy_sh   = r_yy >>> F;
    assign xy_sh   = r_xy >>> (F - 1);
    assign nr      = xx_sh[W-1:0] - yy_sh[W-1:0] + r_cr;
    assign ni      = xy_sh[W-1:0] + r_ci;
    assign dr      = {nr[W-1], nr} - {r_zr[W-1], r_zr};
    assign di      = {ni[W-1], ni} - {r_zi[W-1], r_zi};
    assign quiet   = (dr < EPS_P) && (dr > EPS_N) && (di < EPS_P) && (di > EPS_N);

    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_calm      <= '0;
        end else begin
            // In the done state the output register is handled below.
            if (i_out_ready && r_state != B_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_cr   <= i_job_cr;
                        r_ci   <= i_job_ci;
                        r_zr   <= '0;
                        r_zi   <= '0;
                        r_n    <= '0;
                        r_calm <= '0;
                        r_res.pixel_class <= i_job_tag.pixel_class;
                        r_res.iteration_count <=
                            (i_job_tag.pixel_class == CLS_OUTSIDE) ? 8'd1 : 8'd0;
                        r_state <= i_job_tag.iterate ? B_MUL : B_DONE;
                    end
                end
                B_MUL: begin
                    r_xx1   <= m_xx1;
                    r_xx0   <= m_xx0;
                    r_yy1   <= m_yy1;
                    r_yy0   <= m_yy0;
                    r_xy1   <= m_xy1;
                    r_xy0   <= m_xy0;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_xx    <= combine_pp(r_xx1, r_xx0);
                    r_yy    <= combine_pp(r_yy1, r_yy0);
                    r_xy    <= combine_pp(r_xy1, r_xy0);
                    r_state <= B_EVAL;
                end
                B_EVAL: begin
                    if (escaped) begin
                        r_res.pixel_class     <= CLS_ESCAPED;
                        r_res.iteration_count <= r_n;
                        r_state               <= B_DONE;
                    end else if (r_n == i_max_iterations || r_calm == CALM_LIMIT) begin
                        r_res.pixel_class     <= CLS_INSIDE;
                        r_res.iteration_count <= 8'd0;
                        r_state               <= B_DONE;
                    end else begin
                        r_zr    <= nr;
                        r_zi    <= ni;
                        r_n     <= r_n + 1'b1;
                        r_calm  <= r_calm + {2'b00, quiet};
                        r_state <= B_MUL;
                    end
                end
                B_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_calm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calm <= CALM_LIMIT)
        else $error("quiet-step count ran past its limit");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EVAL) |-> (r_n <= i_max_iterations))
        else $error("orbit ran more steps than the iteration limit");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == B_MUL || r_state == B_DONE))
        else $error("job taken from the queue was not started");

endmodule

// ===== sim/mpc_pixel_scoreboard.sv =====
// Scoreboard of the Mandelbrot pixel classifier: mirrors the configuration registers,
// computes the expected class and count of every accepted pixel and checks the results.
// Uses mpc_pkg.
module mpc_pixel_scoreboard
    import mpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_pixel_in   i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_pixel_out  i_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int FRAC = DEF_FRAC_BITS;
    localparam longint COORD_MAX = 64'sd140737488355327;
    localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

    longint     view_re, view_im;
    logic [46:0] pitch_re, pitch_im;
    logic [7:0]  iter_limit;
    t_pixel_out  expected_pixels[$];

    function automatic logic [127:0] abs_val(longint a);
        logic [63:0] m;
        m = (a < 0) ? 64'(-a) : 64'(a);
        return {64'd0, m};
    endfunction

    function automatic logic [127:0] mag_sq(longint x, longint y);
        return abs_val(x) * abs_val(x) + abs_val(y) * abs_val(y);
    endfunction

    // Product with 43 fraction bits, floored toward minus infinity.
    function automatic longint fix_mul(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  q;
        logic         neg;
        p = abs_val(a) * abs_val(b);
        q = p[106:43];
        neg = (a < 0) != (b < 0);
        if (q > 64'h7FFF_FFFF_FFFF_FFFE) begin
            q = 64'h7FFF_FFFF_FFFF_FFFE;
        end
        if (neg && p[42:0] != 0) begin
            q = q + 64'd1;
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // num/den rounded to nearest in the coordinate format.
    function automatic longint fix_const(longint num, longint den);
        logic [127:0] n;
        n = ({64'd0, 64'(num)} << FRAC) + 128'(den / 2);
        return longint'(n / 128'(den));
    endfunction

    function automatic longint point_coord(longint off, logic [46:0] pitch, longint idx);
        logic [127:0] prod;
        longint p;
        prod = abs_val(idx) * {81'd0, pitch};
        if (prod > 128'(COORD_MAX)) begin
            p = (idx < 0) ? COORD_MIN : COORD_MAX;
        end else begin
            p = (idx < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        end
        if (p > 0 && off > COORD_MAX - p) begin
            return COORD_MAX;
        end
        if (p < 0 && off < COORD_MIN - p) begin
            return COORD_MIN;
        end
        return off + p;
    endfunction

    function automatic logic in_disc(longint x, longint y, longint r);
        return mag_sq(x, y) <= abs_val(r) * abs_val(r);
    endfunction

    function automatic t_pixel_out classify_pixel(t_pixel_in px);
        longint     cr, ci, zr, zi, nr, ni, eps;
        logic [127:0] four;
        int         steps, calm;
        t_pixel_out res;
        cr = point_coord(view_re, pitch_re, longint'($signed(px.column_offset)));
        ci = point_coord(view_im, pitch_im, longint'($signed(px.row_offset)));
        four = 128'd1 << (2 * FRAC + 2);
        res.iteration_count = 8'd0;
        if (mag_sq(cr, ci) > four) begin
            res.pixel_class = CLS_OUTSIDE;
            res.iteration_count = 8'd1;
        end else if (in_disc(cr + fix_const(24, 100), ci, fix_const(49, 100))
                || in_disc(cr, ci + fix_const(30, 100), fix_const(30, 100))
                || in_disc(cr, ci - fix_const(30, 100), fix_const(30, 100))
                || in_disc(cr + fix_const(1, 1), ci, fix_const(23, 100))) begin
            res.pixel_class = CLS_DISC;
        end else begin
            zr = 0;
            zi = 0;
            steps = 0;
            calm = 0;
            eps = fix_const(1, 64'd10000000000);
            while (steps < iter_limit && mag_sq(zr, zi) <= four && calm < CALM_LIMIT) begin
                nr = fix_mul(zr, zr) - fix_mul(zi, zi) + cr;
                ni = fix_mul(zr, zi * 2) + ci;
                steps++;
                // A quiet step moves both parts of z by less than epsilon.
                if (abs_val(ni - zi) < abs_val(eps) && abs_val(nr - zr) < abs_val(eps)) begin
                    calm++;
                end
                zr = nr;
                zi = ni;
            end
            if (mag_sq(zr, zi) <= four) begin
                res.pixel_class = CLS_INSIDE;
            end else begin
                res.pixel_class = CLS_ESCAPED;
                res.iteration_count = 8'(steps);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_out want;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            view_re <= 0;
            view_im <= 0;
            pitch_re <= 47'd58640620148;
            pitch_im <= 47'd58640620148;
            iter_limit <= MAX_ITER_RESET;
            expected_pixels.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OFFSET_RE: view_re <= longint'($signed(i_cfg_data));
                    REG_OFFSET_IM: view_im <= longint'($signed(i_cfg_data));
                    REG_STEP_RE: pitch_re <= i_cfg_data[46:0];
                    REG_STEP_IM: pitch_im <= i_cfg_data[46:0];
                    REG_MAX_ITER: iter_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(classify_pixel(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: class %0d count %0d",
                        i_out_data.pixel_class, i_out_data.iteration_count);
                    errs = errs + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.pixel_class !== i_out_data.pixel_class) begin
                        $error("pixel_class: expected %0d, actual %0d",
                            want.pixel_class, i_out_data.pixel_class);
                        errs = errs + 1;
                    end
                    if (want.iteration_count !== i_out_data.iteration_count) begin
                        $error("iteration_count: expected %0d, actual %0d",
                            want.iteration_count, i_out_data.iteration_count);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ===== sim/mandelbrot_pixel_classifier_tb.sv =====
// Testbench top of the Mandelbrot pixel classifier: clock, reset, stimulus and verdict.
// Uses mpc_pkg, mandelbrot_pixel_classifier and mpc_pixel_scoreboard.
module mandelbrot_pixel_classifier_tb;
    import mpc_pkg::*;

    // One Q4.43 unit, and the first register index that the block does not decode.
    localparam longint ONE_FIX = 64'sd1 << DEF_FRAC_BITS;
    localparam logic [2:0] REG_UNMAPPED_LO = REG_MAX_ITER + 3'd1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_PHASES = 8;

    // Traffic shapes: nobody idles, the sender idles, the receiver stalls, or both.
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_pixel_in   in_data;
    logic        out_valid;
    logic        out_ready;
    t_pixel_out  out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    t_idle_mode  idle_mode;

    mandelbrot_pixel_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mpc_pixel_scoreboard scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The run is cut off well beyond the slowest legal run: 400 pixels at the full limit
    // of 255 steps with long receiver stalls stay far below this.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver decides its ready once per cycle, on the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 70);
                IDLE_BOTH: out_ready <= ($urandom_range(99) >= 30);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    function automatic logic sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 70;
            IDLE_BOTH: return $urandom_range(99) < 30;
            default: return 1'b0;
        endcase
    endfunction

    // Offers one item and returns at the edge that accepts it. Valid is lowered only
    // when a gap follows, so it is never dropped and raised within one step.
    task automatic send_pixel(input int col, input int row);
        @(negedge clk);
        while (sender_gap()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.column_offset <= col[11:0];
        in_data.row_offset <= row[11:0];
        do begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    // Drops valid after the last item and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    // Full-range offsets now and then; otherwise offsets inside the visible span.
    function automatic int pick_offset(int span);
        if ($urandom_range(7) == 0) begin
            return $urandom_range(4095) - 2048;
        end
        return $urandom_range(2 * span) - span;
    endfunction

    longint view_re[NUM_PHASES];
    longint view_im[NUM_PHASES];
    longint pitch_re[NUM_PHASES];
    longint pitch_im[NUM_PHASES];
    int     limit[NUM_PHASES];
    int     span[NUM_PHASES];
    int     items[NUM_PHASES];

    initial begin
        int directed_cols[$];
        int directed_rows[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_OFFSET_RE;
        cfg_data = '0;
        idle_mode = IDLE_NONE;

        // Phase settings. The first views the set near its boundary at the full limit,
        // one drives every register to its extremes, one has a zero iteration limit,
        // and one draws its view and limit at random.
        view_re = '{-ONE_FIX * 3 / 4, -ONE_FIX / 2, 64'sd140737488355327, ONE_FIX * 3 / 10,
            0, -ONE_FIX / 10, 0, -64'sd140737488355328};
        view_im = '{ONE_FIX / 10, 0, -64'sd140737488355328, ONE_FIX / 2,
            0, ONE_FIX * 9 / 10, 0, 64'sd140737488355327};
        pitch_re = '{ONE_FIX / 400, ONE_FIX / 200, 64'sd140737488355327, ONE_FIX / 5000,
            0, ONE_FIX / 20000, 64'sd58640620148, 0};
        pitch_im = '{ONE_FIX / 400, ONE_FIX / 250, 64'sd140737488355327, ONE_FIX / 5000,
            0, ONE_FIX / 20000, 64'sd58640620148, 0};
        limit = '{255, 60, 1, 0, 0, 128, 50, 255};
        span = '{400, 500, 2048, 300, 300, 200, 320, 2048};
        items = '{60, 80, 25, 30, 60, 60, 55, 10};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pixels in the reset view (1/150 per pixel): the corners of the field,
        // c = -2 on the radius, just past it, three of the four disc centres, the cusp and a
        // few boundary points.
        directed_cols = '{0, -2048, 2047, -2048, 2047, -300, 301, -150, 0, 0,
            0, 38, -113, -120, 60, -30, 40, -1, -10, 0};
        directed_rows = '{0, -2048, 2047, 2047, -2048, 0, 0, 0, 45, -45,
            150, 0, 0, 80, -95, 150, 100, -1, -160, 301};
        foreach (directed_cols[k]) begin
            send_pixel(directed_cols[k], directed_rows[k]);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // The random phase draws a view within 1.5 of the origin and a short limit.
            if (ph == 4) begin
                view_re[ph] = longint'($urandom_range(3000)) * ONE_FIX / 1000 - ONE_FIX * 3 / 2;
                view_im[ph] = longint'($urandom_range(3000)) * ONE_FIX / 1000 - ONE_FIX * 3 / 2;
                pitch_re[ph] = ONE_FIX / longint'($urandom_range(2000, 100));
                pitch_im[ph] = ONE_FIX / longint'($urandom_range(2000, 100));
                limit[ph] = $urandom_range(40, 1);
            end
            idle_mode = t_idle_mode'(ph % 4);
            write_reg(REG_OFFSET_RE, 48'(view_re[ph]));
            write_reg(REG_OFFSET_IM, 48'(view_im[ph]));
            // The unused top bit of a step register is set at random; it must be dropped.
            write_reg(REG_STEP_RE, {$urandom_range(1) == 1, 47'(pitch_re[ph])});
            write_reg(REG_STEP_IM, {$urandom_range(1) == 1, 47'(pitch_im[ph])});
            write_reg(REG_MAX_ITER,
                48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FF00 | 48'(limit[ph]));
            // A write to an index the block does not decode must change nothing.
            write_reg(REG_UNMAPPED_LO + 3'($urandom_range(2)), 48'({$urandom, $urandom}));
            @(negedge clk);
            cfg_we <= 1'b0;
            for (int k = 0; k < items[ph]; k++) begin
                send_pixel(pick_offset(span[ph]), pick_offset(span[ph]));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
